[design/tfps_pkg.sv]
// Shared types, codes and the firing schedule of the thyristor pulse sequencer.
package tfps_pkg;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_PHASE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    GATE_ONE   = 2'd0,
    GATE_TWO   = 2'd1,
    GATE_THREE = 2'd2
  } gate_e;

  typedef struct packed {
    logic       op;
    logic [7:0] phase_count;
  } in_t;

  typedef struct packed {
    logic gate_one;
    logic gate_two;
    logic gate_three;
  } out_t;

  typedef struct packed {
    logic       hit;
    gate_e      gate;
    logic [3:0] load;
  } sched_t;

  function automatic sched_t entry(gate_e gate, logic [3:0] load);
    sched_t e;
    e.hit  = 1'b1;
    e.gate = gate;
    e.load = load;
    return e;
  endfunction

  function automatic sched_t sched_lookup(logic [2:0] mode, logic [7:0] step);
    sched_t e;
    e = '{hit: 1'b0, gate: GATE_ONE, load: 4'd0};
    case (mode)
      3'd1: begin
        case (step)
          8'd0:    e = entry(GATE_THREE, 4'd1);
          8'd24:   e = entry(GATE_TWO, 4'd3);
          8'd37:   e = entry(GATE_ONE, 4'd4);
          8'd51:   e = entry(GATE_TWO, 4'd8);
          8'd65:   e = entry(GATE_ONE, 4'd8);
          default: e.hit = 1'b0;
        endcase
      end
      3'd2: begin
        case (step)
          8'd0:    e = entry(GATE_THREE, 4'd1);
          8'd14:   e = entry(GATE_TWO, 4'd4);
          8'd27:   e = entry(GATE_ONE, 4'd4);
          default: e.hit = 1'b0;
        endcase
      end
      3'd3: begin
        case (step)
          8'd0:    e = entry(GATE_THREE, 4'd1);
          8'd11:   e = entry(GATE_TWO, 4'd4);
          8'd28:   e = entry(GATE_ONE, 4'd4);
          default: e.hit = 1'b0;
        endcase
      end
      3'd4: begin
        case (step)
          8'd0:    e = entry(GATE_TWO, 4'd5);
          8'd8:    e = entry(GATE_THREE, 4'd1);
          8'd32:   e = entry(GATE_ONE, 4'd4);
          8'd45:   e = entry(GATE_TWO, 4'd8);
          default: e.hit = 1'b0;
        endcase
      end
      3'd5: begin
        case (step)
          8'd0:    e = entry(GATE_TWO, 4'd5);
          8'd8:    e = entry(GATE_THREE, 4'd1);
          8'd22:   e = entry(GATE_ONE, 4'd4);
          8'd35:   e = entry(GATE_TWO, 4'd8);
          default: e.hit = 1'b0;
        endcase
      end
      3'd6: begin
        case (step)
          8'd0:    e = entry(GATE_THREE, 4'd1);
          default: e.hit = 1'b0;
        endcase
      end
      default: e.hit = 1'b0;
    endcase
    return e;
  endfunction

endpackage

[design/tfps_core.sv]
// Pulse state, mode register and next gate levels of the sequencer.
module tfps_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_wdata_i,
  input  logic             accept_i,
  input  tfps_pkg::in_t    item_i,
  output tfps_pkg::out_t   result_o
);

  logic [2:0] mode_q;
  logic       off_next_q, off_next_d;
  logic [3:0] left_one_q, left_one_d;
  logic [3:0] left_two_q, left_two_d;
  logic       left_three_q, left_three_d;
  logic [2:0] gates_q, gates_d;
  tfps_pkg::sched_t hit;

  assign hit = tfps_pkg::sched_lookup(mode_q, item_i.phase_count);

  always_comb begin
    off_next_d   = off_next_q;
    left_one_d   = left_one_q;
    left_two_d   = left_two_q;
    left_three_d = left_three_q;
    gates_d      = gates_q;
    if (item_i.op == tfps_pkg::OP_PHASE) begin
      if (hit.hit) begin
        case (hit.gate)
          tfps_pkg::GATE_ONE: begin
            left_one_d = hit.load;
            gates_d[0] = 1'b1;
          end
          tfps_pkg::GATE_TWO: begin
            left_two_d = hit.load;
            gates_d[1] = 1'b1;
          end
          tfps_pkg::GATE_THREE: begin
            left_three_d = hit.load[0];
            gates_d[2]   = 1'b1;
          end
          default: gates_d = gates_q;
        endcase
        off_next_d = 1'b1;
      end
    end else begin
      if (off_next_q) begin
        gates_d      = 3'b000;
        left_one_d   = (left_one_q != 4'd0) ? left_one_q - 4'd1 : left_one_q;
        left_two_d   = (left_two_q != 4'd0) ? left_two_q - 4'd1 : left_two_q;
        left_three_d = 1'b0;
      end else begin
        gates_d = {gates_q[2], left_two_q != 4'd0, left_one_q != 4'd0};
      end
      off_next_d = ~off_next_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= 3'd0;
      off_next_q   <= 1'b0;
      left_one_q   <= 4'd0;
      left_two_q   <= 4'd0;
      left_three_q <= 1'b0;
      gates_q      <= 3'b000;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        off_next_q   <= off_next_d;
        left_one_q   <= left_one_d;
        left_two_q   <= left_two_d;
        left_three_q <= left_three_d;
        gates_q      <= gates_d;
      end
    end
  end

  assign result_o.gate_one   = gates_d[0];
  assign result_o.gate_two   = gates_d[1];
  assign result_o.gate_three = gates_d[2];

endmodule

[design/tfps_obuf.sv]
// Result register with a skid stage between the core and the output channel.
module tfps_obuf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tfps_pkg::out_t push_data_i,
  output logic           full_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output tfps_pkg::out_t out_data_o
);

  logic           main_valid_q;
  logic           skid_valid_q;
  tfps_pkg::out_t main_q;
  tfps_pkg::out_t skid_q;
  logic           pop;

  assign pop = main_valid_q & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!main_valid_q || pop) begin
        main_valid_q <= skid_valid_q | push_i;
        skid_valid_q <= 1'b0;
      end else if (push_i) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!main_valid_q || pop) begin
      main_q <= skid_valid_q ? skid_q : push_data_i;
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

endmodule

[design/thyristor_firing_pulse_sequencer_top.sv]
// Top level of the three-gate thyristor firing-pulse sequencer.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o  in_data_i  (tfps_pkg::in_t)
//   out      output     out_valid_o / out_stall_i out_data_o (tfps_pkg::out_t)
//   cfg      input      cfg_we_i                 cfg_wdata_i (sequence_mode)
//
// One item per cycle while in_stall_o is low; each beat's result is registered in the output buffer on acceptance.
// The schedule lookup and the pulse-count update sit between the state and result registers.
// Reset clears the mode, pulse counts, toggle phase and gate levels; no clearing pass.
// A two-entry output buffer keeps accepting while a result is stalled; in_stall_o
// rises only when both entries hold results.
module thyristor_firing_pulse_sequencer_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  tfps_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output tfps_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_wdata_i
);

  logic           accept;
  logic           full;
  tfps_pkg::out_t result;

  assign in_stall_o = full;
  assign accept     = in_valid_i & ~full;

  tfps_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .item_i      (in_data_i),
    .result_o    (result)
  );

  tfps_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (result),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[design/tfps_checker.sv]
// Port-level checks of the sequencer and their binding to the top level.
module tfps_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input tfps_pkg::out_t out_data_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted beat left no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result dropped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind thyristor_firing_pulse_sequencer_top tfps_checker u_tfps_checker (.*);
